[rtl/agsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate-group sector mapper: shared definitions
// Types, register codes, state encoding and constants for the modules of the
// mapper.
// ----------------------------------------------------------------------------
package agsm_pkg;

	localparam int unsigned DEF_MAX_RUNS = 64;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned ADDR_W       = 5;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned SECTOR_W     = 32;
	localparam int unsigned GROUP_W      = 16;
	localparam int unsigned SBYTES_W     = 14;
	localparam int unsigned OFFSET_W     = 47;
	localparam int unsigned LENGTH_W     = 45;
	localparam logic [SBYTES_W-1:0] SECTOR_BYTES_RST = 14'd512;

	typedef enum logic [2:0] {
		REG_GROUP_SIZE     = 3'd0,
		REG_SPARE_COUNT    = 3'd1,
		REG_SPARE_OFFSET   = 3'd2,
		REG_FRONT_SECTORS  = 3'd3,
		REG_PARTITION_BASE = 3'd4,
		REG_SECTOR_BYTES   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [GROUP_W-1:0]  group_size;
		logic [GROUP_W-1:0]  spare_count;
		logic [GROUP_W-1:0]  spare_offset;
		logic [SECTOR_W-1:0] front_sectors;
		logic [SECTOR_W-1:0] partition_base;
		logic [SBYTES_W-1:0] sector_bytes;
	} cfg_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] start_sector;
		logic [SECTOR_W-1:0] sector_count;
	} req_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] byte_offset;
		logic [LENGTH_W-1:0] byte_length;
		logic                last_run;
		logic                truncated;
	} rsp_t;

	// One classified request waiting for the back end.
	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [SECTOR_W-1:0] count;
		logic                grouped;
	} job_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] quot;
		logic [GROUP_W-1:0]  rem;
	} div_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CALC_POS,
		ST_CALC_RUN,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_EMIT
	} back_state_t;

endpackage

[rtl/agsm_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate-group sector mapper: configuration registers
// APB-style register file holding the disk geometry and partition settings.
// ----------------------------------------------------------------------------
module agsm_regs import agsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_size     <= '0;
			cfg_q.spare_count    <= '0;
			cfg_q.spare_offset   <= '0;
			cfg_q.front_sectors  <= '0;
			cfg_q.partition_base <= '0;
			cfg_q.sector_bytes   <= SECTOR_BYTES_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GROUP_SIZE:     cfg_q.group_size     <= pwdata[GROUP_W-1:0];
				REG_SPARE_COUNT:    cfg_q.spare_count    <= pwdata[GROUP_W-1:0];
				REG_SPARE_OFFSET:   cfg_q.spare_offset   <= pwdata[GROUP_W-1:0];
				REG_FRONT_SECTORS:  cfg_q.front_sectors  <= pwdata[SECTOR_W-1:0];
				REG_PARTITION_BASE: cfg_q.partition_base <= pwdata[SECTOR_W-1:0];
				REG_SECTOR_BYTES:   cfg_q.sector_bytes   <= pwdata[SBYTES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_GROUP_SIZE:     prdata = DATA_W'(cfg_q.group_size);
			REG_SPARE_COUNT:    prdata = DATA_W'(cfg_q.spare_count);
			REG_SPARE_OFFSET:   prdata = DATA_W'(cfg_q.spare_offset);
			REG_FRONT_SECTORS:  prdata = DATA_W'(cfg_q.front_sectors);
			REG_PARTITION_BASE: prdata = DATA_W'(cfg_q.partition_base);
			REG_SECTOR_BYTES:   prdata = DATA_W'(cfg_q.sector_bytes);
			default:            prdata = '0;
		endcase
	end

endmodule

[rtl/agsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate-group sector mapper: front end
// Accepts requests, rebases them onto the partition, decides whether the
// disk is grouped and queues the result for the back end.
// ----------------------------------------------------------------------------
module agsm_front import agsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic job_valid,
	output job_t job,
	input  logic job_pop
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	job_t             job_in;
	logic             push;
	logic             pop;

	assign req_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign job_valid = (cnt_q != '0);
	assign push      = req_valid & req_ready;
	assign pop       = job_pop & job_valid;
	assign job       = mem_q[rd_ptr_q];

	// The partition base wraps modulo 2^32, as does the running sector later.
	always_comb begin
		job_in.sector  = req.start_sector + cfg.partition_base;
		job_in.count   = req.sector_count;
		job_in.grouped = (cfg.group_size > cfg.spare_count);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/agsm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate-group sector mapper: sector divider
// Restoring divider, one quotient bit per cycle, giving the group number and
// the position inside the usable part of the group.
// ----------------------------------------------------------------------------
module agsm_div import agsm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SECTOR_W-1:0] dividend,
	input  logic [GROUP_W-1:0]  divisor,
	output logic                busy,
	output logic                done,
	output div_res_t            res
);

	localparam int unsigned STEP_W = $clog2(SECTOR_W);

	logic [SECTOR_W-1:0] quo_q;
	logic [GROUP_W-1:0]  rem_q;
	logic [GROUP_W-1:0]  dsr_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;
	logic [GROUP_W:0]    trial;
	logic [GROUP_W:0]    diff;
	logic                take;

	assign trial = {rem_q, quo_q[SECTOR_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign take  = (trial >= {1'b0, dsr_q});

	assign busy     = busy_q;
	assign done     = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SECTOR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder always stays below the divisor, so 16 bits hold it.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SECTOR_W-2:0], take};
			rem_q <= take ? diff[GROUP_W-1:0] : trial[GROUP_W-1:0];
		end
	end

endmodule

[rtl/agsm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate-group sector mapper: back end
// Splits each queued request into physical runs and scales them to bytes,
// holding each finished run in an output register until it is taken.
// ----------------------------------------------------------------------------
module agsm_back import agsm_pkg::*; #(
	parameter int unsigned MAX_RUNS = DEF_MAX_RUNS
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned RUN_W  = $clog2(MAX_RUNS + 1);
	localparam int unsigned HALF_W = 24;
	localparam int unsigned QG_W   = SECTOR_W + GROUP_W;

	back_state_t state_q, state_d;

	logic [SECTOR_W-1:0]               sector_q;
	logic [SECTOR_W-1:0]               count_q;
	logic                              grouped_q;
	logic [RUN_W-1:0]                  runs_q;
	logic [GROUP_W:0]                  pos_q;
	logic [QG_W-1:0]                   qg_q;
	logic [SECTOR_W-1:0]               limit_q;
	logic [OFFSET_W-1:0]               phys_q;
	logic [HALF_W+SBYTES_W-1:0]        plo_q;
	logic [OFFSET_W-HALF_W+SBYTES_W-1:0] phi_q;
	logic [LENGTH_W-1:0]               len_q;
	rsp_t                              rsp_q;
	logic                              rsp_valid_q;

	logic                              div_start;
	logic                              div_busy;
	logic                              div_done;
	div_res_t                          div_res;
	logic [GROUP_W-1:0]                usable;
	logic                              rsp_load;

	logic [GROUP_W:0]                  pos_adj;
	logic [QG_W-1:0]                   qg_prod;
	logic [GROUP_W+1:0]                lim_raw;
	logic [SECTOR_W-1:0]               limit_d;
	logic [OFFSET_W-1:0]               phys_d;
	logic [SECTOR_W+SBYTES_W-1:0]      len_prod;
	logic [OFFSET_W-1:0]               off_sum;
	logic                              run_done;
	logic                              run_cut;

	assign usable = cfg.group_size - cfg.spare_count;

	agsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sector_q),
		.divisor  (usable),
		.busy     (div_busy),
		.done     (div_done),
		.res      (div_res)
	);

	// Positions at or past the spare block are pushed over it.
	always_comb begin
		pos_adj = {1'b0, div_res.rem};
		if (div_res.rem >= cfg.spare_offset) begin
			pos_adj = {1'b0, div_res.rem} + {1'b0, cfg.spare_count};
		end
		qg_prod = div_res.quot * cfg.group_size;
	end

	// On a grouped disk a run ends at the spare block or, past it, at the spare
	// block of the next group; the remaining count may cut it shorter.
	always_comb begin
		if (pos_q < {1'b0, cfg.spare_offset}) begin
			lim_raw = {2'b0, cfg.spare_offset} - {1'b0, pos_q};
		end else begin
			lim_raw = {2'b0, cfg.group_size} - {1'b0, pos_q} + {2'b0, cfg.spare_offset};
		end
		if (grouped_q) begin
			limit_d = (count_q < SECTOR_W'(lim_raw)) ? count_q : SECTOR_W'(lim_raw);
			phys_d  = qg_q[OFFSET_W-1:0] + OFFSET_W'(pos_q) + OFFSET_W'(cfg.front_sectors);
		end else begin
			limit_d = count_q;
			phys_d  = OFFSET_W'(sector_q) + OFFSET_W'(cfg.front_sectors);
		end
	end

	assign len_prod = limit_q * cfg.sector_bytes;
	assign off_sum  = OFFSET_W'(plo_q) + {phi_q[OFFSET_W-HALF_W-1:0], {HALF_W{1'b0}}};
	assign run_done = (count_q == '0);
	assign run_cut  = !run_done && (runs_q >= RUN_W'(MAX_RUNS));

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = job.grouped ? ST_DIV_GO : ST_CALC_RUN;
				end
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_CALC_POS;
				end
			end
			ST_CALC_POS: state_d = ST_CALC_RUN;
			ST_CALC_RUN: state_d = ST_MUL_LO;
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = (run_done || run_cut) ? ST_IDLE : ST_DIV_GO;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			runs_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (job_pop) begin
				runs_q <= '0;
			end else if (state_q == ST_MUL_LO) begin
				runs_q <= runs_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			sector_q  <= job.sector;
			count_q   <= job.count;
			grouped_q <= job.grouped;
		end
		if (state_q == ST_CALC_POS) begin
			pos_q <= pos_adj;
			qg_q  <= qg_prod;
		end
		if (state_q == ST_CALC_RUN) begin
			limit_q <= limit_d;
			phys_q  <= phys_d;
		end
		if (state_q == ST_MUL_LO) begin
			plo_q    <= phys_q[HALF_W-1:0] * cfg.sector_bytes;
			len_q    <= len_prod[LENGTH_W-1:0];
			sector_q <= sector_q + limit_q;
			count_q  <= count_q - limit_q;
		end
		if (state_q == ST_MUL_HI) begin
			phi_q <= phys_q[OFFSET_W-1:HALF_W] * cfg.sector_bytes;
		end
		if (rsp_load) begin
			rsp_q.byte_offset <= off_sum;
			rsp_q.byte_length <= len_q;
			rsp_q.last_run    <= run_done || run_cut;
			rsp_q.truncated   <= run_cut;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_trunc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.truncated |-> rsp_q.last_run)
		else $error("truncated run not marked as last");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy)
		else $error("divider still busy with no request in progress");

	a_run_limit: assert property (@(posedge clk) disable iff (!arst_n)
		runs_q <= RUN_W'(MAX_RUNS))
		else $error("run counter beyond the run limit");

	a_ungrouped_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && !grouped_q |-> run_done)
		else $error("ungrouped request needs more than one run");

endmodule

[rtl/alt_group_sector_mapper_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate-group sector mapper
// Splits a partition-relative read request into physical byte runs on a disk
// whose alternate-sector groups reserve a block of spare sectors.
// ----------------------------------------------------------------------------
// For each run on a grouped disk the back end uses the 32-step serial divider,
// then works out the position, the run limit and the two halves of the byte
// offset; an ungrouped request skips the divider and needs a single run.
// Two requests can be queued ahead of the back end; a finished run waits in the
// output register while the next one is worked out.
// Reset clears all control state and the registers; sector_bytes resets to 512.
module alt_group_sector_mapper_core import agsm_pkg::*; #(
	parameter int unsigned MAX_RUNS = DEF_MAX_RUNS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;
	logic job_valid;
	job_t job;
	logic job_pop;

	agsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	agsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	agsm_back #(
		.MAX_RUNS (MAX_RUNS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
